@@ hdl/miss_history_lru_prefetcher_defines.svh @@
// Assertion macros for the miss-history prefetcher top level.
`ifndef MISS_HISTORY_LRU_PREFETCHER_DEFINES_SVH
`define MISS_HISTORY_LRU_PREFETCHER_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define MHLP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mhlp assertion failed");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define MHLP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mhlp assertion failed");

`endif

@@ hdl/mhlp_pkg.sv @@
// Types and constants shared by the miss-history prefetcher.
package mhlp_pkg;

	localparam int unsigned HISTORY_ENTRIES_DEF = 64;
	localparam int unsigned ADDR_W = 32;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	// Per-cycle control broadcast to every cell.
	typedef struct packed {
		logic compare;
		logic update;
	} cell_ctl_t;

endpackage

@@ hdl/mhlp_cell.sv @@
// One history cell: an address, its valid bit and a registered match flag.
module mhlp_cell
	import mhlp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  addr_t     cmp_addr,
	input  addr_t     prev_addr,
	input  logic      prev_valid,
	input  logic      seen_in,
	output addr_t     addr,
	output logic      valid,
	output logic      hit,
	output logic      seen_out
);

	addr_t addr_q;
	logic  valid_q;
	logic  hit_q;
	logic  shift;

	// A cell moves back one place unless the match sits closer to the front.
	assign shift    = ctl.update & ~seen_in;
	assign seen_out = seen_in | hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctl.compare) begin
				hit_q <= valid_q & (addr_q == cmp_addr);
			end
			if (shift) begin
				valid_q <= prev_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			addr_q <= prev_addr;
		end
	end

	assign addr  = addr_q;
	assign valid = valid_q;
	assign hit   = hit_q;

endmodule

@@ hdl/miss_history_lru_prefetcher.sv @@
// Top level of the miss-history LRU prefetcher: control and the row of cells.
//
// Channel   | Handshake          | Beat contents
// ----------+--------------------+-----------------------------------------
// access    | start & !busy      | access_address, was_miss
// result    | done (one cycle)   | prefetch_issued, prefetch_address
//
// Each access first compares the address with every cell in parallel and
// registers the per-cell match, then shifts the row and registers the
// result. A new access is taken during the shift, so it can enter while
// the previous one shifts. The result shows on done in the cycle after the
// shift. Reset clears all valid bits at once; no clearing pass is needed.
// The receiver cannot stall: every result beat is presented exactly once.
`include "miss_history_lru_prefetcher_defines.svh"

module miss_history_lru_prefetcher
	import mhlp_pkg::*;
#(
	parameter int unsigned HISTORY_ENTRIES = HISTORY_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] access_address,
	input  logic        was_miss,
	output logic        done,
	output logic        prefetch_issued,
	output logic [31:0] prefetch_address
);

	// The row is kept in recency order: cell 0 holds the most recent miss.
	// On a miss the cells in front of the match (or all cells when there is
	// no match) move back one place and the address enters at cell 0; the
	// last cell falls off the end, which drops the least recent entry.

	state_t    state_q;
	state_t    state_next;
	cell_ctl_t ctl;

	addr_t addr_q;
	logic  miss_q;

	logic  done_q;
	logic  issued_q;
	addr_t pf_addr_q;

	addr_t                      cell_addr  [HISTORY_ENTRIES];
	logic  [HISTORY_ENTRIES-1:0] cell_valid;
	logic  [HISTORY_ENTRIES-1:0] cell_hit;
	logic  [HISTORY_ENTRIES:0]   seen;

	logic accept;
	logic any_hit;

	// ---- control ------------------------------------------------------

	assign accept = start & ~busy;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: state_next = start ? ST_CMP : ST_IDLE;
			ST_CMP:  state_next = ST_UPD;
			ST_UPD:  state_next = start ? ST_CMP : ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = 1'b0;
		ctl.compare = 1'b0;
		ctl.update  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_CMP: begin
				busy        = 1'b1;
				ctl.compare = 1'b1;
			end
			ST_UPD: begin
				// Hits leave the table alone.
				ctl.update = miss_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			done_q  <= (state_q == ST_UPD);
		end
	end

	// Hold the accepted beat; it is overwritten only at the next accept,
	// which happens no earlier than the shift edge that consumes it.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= access_address;
			miss_q <= was_miss;
		end
	end

	// ---- row of cells -------------------------------------------------

	assign seen[0] = 1'b0;

	for (genvar i = 0; i < HISTORY_ENTRIES; i++) begin : g_cell
		addr_t prev_addr;
		logic  prev_valid;

		if (i == 0) begin : g_front
			assign prev_addr  = addr_q;
			assign prev_valid = 1'b1;
		end else begin : g_rest
			assign prev_addr  = cell_addr[i-1];
			assign prev_valid = cell_valid[i-1];
		end

		mhlp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.cmp_addr   (addr_q),
			.prev_addr  (prev_addr),
			.prev_valid (prev_valid),
			.seen_in    (seen[i]),
			.addr       (cell_addr[i]),
			.valid      (cell_valid[i]),
			.hit        (cell_hit[i]),
			.seen_out   (seen[i+1])
		);
	end

	assign any_hit = seen[HISTORY_ENTRIES];

	// ---- result -------------------------------------------------------

	// Register the result at the shift edge; drop the address on no prefetch.
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			issued_q  <= miss_q & any_hit;
			pf_addr_q <= (miss_q & any_hit) ? addr_q : '0;
		end
	end

	assign done             = done_q;
	assign prefetch_issued  = issued_q & done_q;
	assign prefetch_address = pf_addr_q;

	// ---- checks -------------------------------------------------------

	`MHLP_ASSERT_NEXT(a_upd_gives_done, state_q == ST_UPD, done)
	`MHLP_ASSERT_NOW(a_single_match, state_q == ST_UPD, $onehot0(cell_hit))
	`MHLP_ASSERT_NOW(a_zero_addr_no_pf, done && !prefetch_issued, prefetch_address == '0)
	`MHLP_ASSERT_NEXT(a_front_loaded, ctl.update, cell_valid[0] && cell_addr[0] == $past(addr_q))
	`MHLP_ASSERT_NEXT(a_accept_busy, accept, busy && state_q == ST_CMP)

endmodule
